// File: hw/rtl/mff_pkg.sv
// shared types and constants of the message fragment framer
`timescale 1ns / 1ps

package mff_pkg;

   localparam int FRAME_BUFFER_BYTES = 64;
   localparam int CHUNK_W = 6;
   localparam int CHUNK_CAP_RAW = FRAME_BUFFER_BYTES - 12;
   localparam int CHUNK_CAP_INT = (CHUNK_CAP_RAW > 63) ? 63 :
                                  ((CHUNK_CAP_RAW < 1) ? 1 : CHUNK_CAP_RAW);
   localparam logic [CHUNK_W-1:0] CHUNK_CAP = CHUNK_W'(CHUNK_CAP_INT);

   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] SYNC0_BYTE = 8'hBC;
   localparam logic [7:0] SYNC1_BYTE = 8'hCF;
   localparam logic [7:0] LEN_BIAS = 8'd6;

   localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RESET = 6'd52;
   localparam logic [7:0] FRAME_TYPE_RESET = 8'h00;

   typedef enum logic [0:0] {
      CSR_CHUNK_LIMIT = 1'b0,
      CSR_FRAME_TYPE  = 1'b1
   } csr_index_type;

   // one input byte as seen by the back end
   typedef struct packed {
      logic [7:0]  data;
      logic        hdr;
      logic        close;
      logic        last;
      logic [7:0]  len_byte;
      logic [15:0] id;
      logic [15:0] rep;
      logic [7:0]  total;
      logic [7:0]  index;
   } cmd_type;

endpackage

// File: hw/rtl/mff_ifs.sv
// request and response channel interfaces of the framer
`timescale 1ns / 1ps

interface mff_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [7:0]  msg_len;
   logic [15:0] msg_id;
   logic [15:0] reported_len;

   modport source (output valid, data_byte, msg_len, msg_id, reported_len, input ready);
   modport sink (input valid, data_byte, msg_len, msg_id, reported_len, output ready);
endinterface

interface mff_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       message_end;
   logic       run_end;

   modport source (output valid, out_byte, frame_end, message_end, run_end, input ready);
   modport sink (input valid, out_byte, frame_end, message_end, run_end, output ready);
endinterface

// File: hw/rtl/mff_div.sv
// bit-serial restoring divider for the fragment count
`timescale 1ns / 1ps

module mff_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [7:0]                  numer,
   input  logic [mff_pkg::CHUNK_W-1:0] denom,
   output logic                        done,
   output logic [7:0]                  quot
);
   import mff_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [CHUNK_W-1:0]  rem_ff, rem_in;
   logic [CHUNK_W-1:0]  den_ff, den_in;
   logic [7:0]          quot_ff, quot_in;
   logic [CHUNK_W:0]    trial;
   logic [CHUNK_W:0]    diff;
   logic                ge;

   always_comb begin
      trial   = {rem_ff, quot_ff[7]};
      ge      = (trial >= {1'b0, den_ff});
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         rem_in  = '0;
         den_in  = denom;
         quot_in = numer;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
         quot_in = {quot_ff[6:0], ge};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: hw/rtl/mff_front.sv
// front end: takes message bytes, tracks chunk and fragment position
`timescale 1ns / 1ps

module mff_front (
   input  logic                        clock,
   input  logic                        reset,
   mff_req_if.sink                     req_ch,
   input  logic [mff_pkg::CHUNK_W-1:0] chunk_limit,
   output logic                        q_push,
   output mff_pkg::cmd_type            q_cmd,
   input  logic                        q_full
);
   import mff_pkg::*;

   typedef enum logic [1:0] {
      ST_TAKE,
      ST_DIV,
      ST_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         data_ff, data_in;
   logic [7:0]         offset_ff, offset_in;
   logic [CHUNK_W-1:0] pos_ff, pos_in;
   logic [CHUNK_W-1:0] size_ff, size_in;
   logic [7:0]         index_ff, index_in;
   logic [7:0]         total_ff, total_in;
   logic [7:0]         len_ff, len_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [15:0]        id_ff, id_in;
   logic [15:0]        rep_ff, rep_in;

   logic               accept;
   logic [7:0]         len_eff;
   logic [CHUNK_W-1:0] chunk_eff;
   logic               div_start;
   logic               div_done;
   logic [7:0]         div_quot;
   logic [7:0]         left;
   logic [CHUNK_W-1:0] size;
   logic [CHUNK_W-1:0] pos_next;
   logic [7:0]         offset_next;
   logic               hdr;
   logic               close;
   logic               last;

   assign req_ch.ready = (state_ff == ST_TAKE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      len_eff = (req_ch.msg_len == 8'd0) ? 8'd1 : req_ch.msg_len;
      if (chunk_limit == '0) begin
         chunk_eff = CHUNK_W'(1);
      end else if (chunk_limit > CHUNK_CAP) begin
         chunk_eff = CHUNK_CAP;
      end else begin
         chunk_eff = chunk_limit;
      end
   end

   assign div_start = accept && (offset_ff == 8'd0);

   mff_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (len_eff - 8'd1),
      .denom (chunk_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // command for the captured byte
   always_comb begin
      hdr         = (pos_ff == '0);
      left        = len_ff - offset_ff;
      if (hdr) begin
         size = (left < {2'b00, chunk_ff}) ? left[CHUNK_W-1:0] : chunk_ff;
      end else begin
         size = size_ff;
      end
      pos_next    = pos_ff + CHUNK_W'(1);
      offset_next = offset_ff + 8'd1;
      close       = (pos_next >= size);
      last        = close && (offset_next == len_ff);

      q_cmd.data     = data_ff;
      q_cmd.hdr      = hdr;
      q_cmd.close    = close;
      q_cmd.last     = last;
      q_cmd.len_byte = {2'b00, size} + LEN_BIAS;
      q_cmd.id       = id_ff;
      q_cmd.rep      = rep_ff;
      q_cmd.total    = total_ff;
      q_cmd.index    = index_ff;
   end

   assign q_push = (state_ff == ST_PUSH) && !q_full;

   always_comb begin
      state_in  = state_ff;
      data_in   = data_ff;
      offset_in = offset_ff;
      pos_in    = pos_ff;
      size_in   = size_ff;
      index_in  = index_ff;
      total_in  = total_ff;
      len_in    = len_ff;
      chunk_in  = chunk_ff;
      id_in     = id_ff;
      rep_in    = rep_ff;
      unique case (state_ff)
         ST_TAKE: begin
            if (accept) begin
               data_in = req_ch.data_byte;
               if (offset_ff == 8'd0) begin
                  len_in   = len_eff;
                  chunk_in = chunk_eff;
                  id_in    = req_ch.msg_id;
                  rep_in   = req_ch.reported_len;
                  pos_in   = '0;
                  index_in = 8'd0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               total_in = div_quot + 8'd1;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               size_in = size;
               if (close) begin
                  pos_in    = '0;
                  index_in  = last ? 8'd0 : (index_ff + 8'd1);
                  offset_in = last ? 8'd0 : offset_next;
               end else begin
                  pos_in    = pos_next;
                  offset_in = offset_next;
               end
               state_in = ST_TAKE;
            end
         end
         default: state_in = ST_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_TAKE;
         offset_ff <= 8'd0;
         pos_ff    <= '0;
         size_ff   <= '0;
         index_ff  <= 8'd0;
         total_ff  <= 8'd0;
         len_ff    <= 8'd0;
         chunk_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
         pos_ff    <= pos_in;
         size_ff   <= size_in;
         index_ff  <= index_in;
         total_ff  <= total_in;
         len_ff    <= len_in;
         chunk_ff  <= chunk_in;
      end
      data_ff <= data_in;
      id_ff   <= id_in;
      rep_ff  <= rep_in;
   end

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside of its wait state");

   a_offset_in_message: assert property (@(posedge clock) disable iff (reset)
      (offset_ff != 8'd0) |-> (offset_ff < len_ff))
      else $error("byte offset ran past the message length");

   a_push_fills_chunk: assert property (@(posedge clock) disable iff (reset)
      (q_push && !close) |=> (pos_ff != '0))
      else $error("chunk position lost inside a chunk");

endmodule

// File: hw/rtl/mff_queue.sv
// two-entry command queue between front and back end
`timescale 1ns / 1ps

module mff_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mff_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mff_pkg::cmd_type pop_cmd
);
   import mff_pkg::*;

   logic [1:0] count_ff, count_in;
   cmd_type    slot0_ff, slot0_in;
   cmd_type    slot1_ff, slot1_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = slot0_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop)) begin
            slot0_in = push_cmd;
         end else begin
            slot1_in = push_cmd;
         end
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("command queue overflow");

endmodule

// File: hw/rtl/mff_back.sv
// back end: emits frame bytes for each command, and fletcher-style sums (modulo 256) when a command closes a chunk
`timescale 1ns / 1ps

module mff_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  mff_pkg::cmd_type q_cmd,
   input  logic [7:0]       frame_type,
   mff_rsp_if.source        rsp_ch
);
   import mff_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC0,
      ST_SYNC1,
      ST_TYPE,
      ST_LEN,
      ST_ID_LO,
      ST_ID_HI,
      ST_REP_LO,
      ST_REP_HI,
      ST_TOTAL,
      ST_INDEX,
      ST_DATA,
      ST_SUM0,
      ST_SUM1
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   logic [7:0] sum_low_ff, sum_low_in;
   logic [7:0] sum_high_ff, sum_high_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       fe_ff, fe_in;
   logic       me_ff, me_in;
   logic       re_ff, re_in;

   logic       slot_free;
   logic       emit;
   logic [7:0] b;
   logic       summed;
   logic [7:0] base_low;
   logic [7:0] base_high;
   logic [7:0] new_low;

   assign q_ready   = (state_ff == ST_IDLE);
   assign slot_free = !valid_ff || rsp_ch.ready;
   assign emit      = (state_ff != ST_IDLE) && slot_free;

   always_comb begin
      summed = 1'b1;
      unique case (state_ff)
         ST_SYNC0: begin
            b      = SYNC0_BYTE;
            summed = 1'b0;
         end
         ST_SYNC1: begin
            b      = SYNC1_BYTE;
            summed = 1'b0;
         end
         ST_TYPE:   b = frame_type;
         ST_LEN:    b = cmd_ff.len_byte;
         ST_ID_LO:  b = cmd_ff.id[7:0];
         ST_ID_HI:  b = cmd_ff.id[15:8];
         ST_REP_LO: b = cmd_ff.rep[7:0];
         ST_REP_HI: b = cmd_ff.rep[15:8];
         ST_TOTAL:  b = cmd_ff.total;
         ST_INDEX:  b = cmd_ff.index;
         ST_DATA:   b = cmd_ff.data;
         ST_SUM0: begin
            b      = sum_low_ff;
            summed = 1'b0;
         end
         ST_SUM1: begin
            b      = sum_high_ff;
            summed = 1'b0;
         end
         default: begin
            b      = 8'd0;
            summed = 1'b0;
         end
      endcase
   end

   // sums restart at the type byte
   always_comb begin
      base_low  = (state_ff == ST_TYPE) ? 8'd0 : sum_low_ff;
      base_high = (state_ff == ST_TYPE) ? 8'd0 : sum_high_ff;
      new_low   = base_low + b;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      valid_in    = slot_free ? 1'b0 : valid_ff;
      byte_in     = byte_ff;
      fe_in       = fe_ff;
      me_in       = me_ff;
      re_in       = re_ff;
      if (state_ff == ST_IDLE) begin
         if (q_valid) begin
            cmd_in   = q_cmd;
            state_in = q_cmd.hdr ? ST_SYNC0 : ST_DATA;
         end
      end else if (emit) begin
         valid_in = 1'b1;
         byte_in  = b;
         fe_in    = (state_ff == ST_SUM1);
         me_in    = (state_ff == ST_SUM1) && cmd_ff.last;
         re_in    = (state_ff == ST_SUM1) || ((state_ff == ST_DATA) && !cmd_ff.close);
         if (summed) begin
            sum_low_in  = new_low;
            sum_high_in = base_high + new_low;
         end
         unique case (state_ff)
            ST_SYNC0:  state_in = ST_SYNC1;
            ST_SYNC1:  state_in = ST_TYPE;
            ST_TYPE:   state_in = ST_LEN;
            ST_LEN:    state_in = ST_ID_LO;
            ST_ID_LO:  state_in = ST_ID_HI;
            ST_ID_HI:  state_in = ST_REP_LO;
            ST_REP_LO: state_in = ST_REP_HI;
            ST_REP_HI: state_in = ST_TOTAL;
            ST_TOTAL:  state_in = ST_INDEX;
            ST_INDEX:  state_in = ST_DATA;
            ST_DATA:   state_in = cmd_ff.close ? ST_SUM0 : ST_IDLE;
            ST_SUM0:   state_in = ST_SUM1;
            ST_SUM1:   state_in = ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= 1'b0;
         sum_low_ff  <= 8'd0;
         sum_high_ff <= 8'd0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
      end
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      fe_ff   <= fe_in;
      me_ff   <= me_in;
      re_ff   <= re_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.frame_end   = fe_ff;
   assign rsp_ch.message_end = me_ff;
   assign rsp_ch.run_end     = re_ff;

   a_close_marks_frame_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SUM1) && slot_free) |=> (valid_ff && fe_ff && re_ff))
      else $error("closing checksum byte lost its end marks");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> (state_ff == ST_SYNC0 || state_ff == ST_DATA))
      else $error("command taken without starting its byte sequence");

endmodule

// File: hw/rtl/message_fragment_framer.sv
// top level of the message fragment framer
// A message enters one byte per transaction; msg_len, msg_id and reported_len are taken from
// the first byte only. The front end captures each byte and hands it to a two-entry command
// queue, waiting while it is full; a message's first byte also waits for the fragment count
// from an eight-step bit-serial divider. The back end emits one frame byte per cycle while
// the response side is ready, going idle between commands: a chunk-opening byte gives eleven
// bytes (header and data), a closing byte adds the two checksum bytes, so a transaction
// yields one to thirteen response bytes and response-side frame overhead sets the sustained
// rate. The chunk limit is sampled at each message start, frame_type at each frame header;
// the user must write both through the csr port while idle; the block does not enforce this.
`timescale 1ns / 1ps

module message_fragment_framer (
   input  logic                            clock,
   input  logic                            reset,
   mff_req_if.sink                         req_ch,
   mff_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  mff_pkg::csr_index_type          csr_index,
   input  logic [mff_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mff_pkg::*;

   logic [CHUNK_W-1:0] chunk_limit_ff, chunk_limit_in;
   logic [7:0]         frame_type_ff, frame_type_in;

   logic    q_push;
   logic    q_full;
   cmd_type push_cmd;
   logic    q_valid;
   logic    q_ready;
   cmd_type pop_cmd;

   always_comb begin
      chunk_limit_in = chunk_limit_ff;
      frame_type_in  = frame_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_LIMIT: chunk_limit_in = csr_wdata[CHUNK_W-1:0];
            CSR_FRAME_TYPE:  frame_type_in  = csr_wdata[7:0];
            default:         chunk_limit_in = chunk_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
         frame_type_ff  <= FRAME_TYPE_RESET;
      end else begin
         chunk_limit_ff <= chunk_limit_in;
         frame_type_ff  <= frame_type_in;
      end
   end

   mff_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .chunk_limit (chunk_limit_ff),
      .q_push      (q_push),
      .q_cmd       (push_cmd),
      .q_full      (q_full)
   );

   mff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_cmd   (pop_cmd)
   );

   mff_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (pop_cmd),
      .frame_type (frame_type_ff),
      .rsp_ch     (rsp_ch)
   );

endmodule
